@@ design/sds_pkg.sv @@
// Shared types and constants for the display command sequencer.
// No dependencies; imported by every module of the block.
package sds_pkg;

	localparam int NSLOT = 18;
	localparam int SLOT_W = 5;

	localparam logic [2:0] CFG_COLUMN_OFFSET = 3'd0;
	localparam logic [2:0] CFG_ROW_OFFSET    = 3'd1;
	localparam logic [2:0] CFG_MEM_ACCESS    = 3'd2;
	localparam logic [2:0] CFG_INVERT        = 3'd3;
	localparam logic [2:0] CFG_RESET_PIN     = 3'd4;
	localparam logic [2:0] CFG_RAIL_CTRL     = 3'd5;

	localparam logic [1:0] REQ_WINDOW = 2'd0;
	localparam logic [1:0] REQ_PIXEL  = 2'd1;
	localparam logic [1:0] REQ_POWER  = 2'd2;
	localparam logic [1:0] REQ_INIT   = 2'd3;

	typedef enum logic [1:0] {
		PWR_ON    = 2'd0,
		PWR_SLEEP = 2'd1,
		PWR_OFF   = 2'd2
	} pwr_state_t;

	// power target code that is not a state
	localparam logic [1:0] PWR_UNKNOWN = 2'd3;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_PIN  = 2'd1;
	localparam logic [1:0] KIND_RAIL = 2'd2;

	localparam logic [7:0] CMD_SOFT_RESET  = 8'h01;
	localparam logic [7:0] CMD_SLEEP_IN    = 8'h10;
	localparam logic [7:0] CMD_SLEEP_OUT   = 8'h11;
	localparam logic [7:0] CMD_NORMAL_MODE = 8'h13;
	localparam logic [7:0] CMD_INVERT_OFF  = 8'h20;
	localparam logic [7:0] CMD_INVERT_ON   = 8'h21;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h29;
	localparam logic [7:0] CMD_COL_ADDR    = 8'h2A;
	localparam logic [7:0] CMD_ROW_ADDR    = 8'h2B;
	localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
	localparam logic [7:0] CMD_ADDR_MODE   = 8'h36;
	localparam logic [7:0] CMD_PIXEL_FMT   = 8'h3A;
	localparam logic [7:0] PIXEL_FMT_565   = 8'h55;

	// window program slots
	localparam logic [SLOT_W-1:0] WS_COL_CMD   = 5'd0;
	localparam logic [SLOT_W-1:0] WS_XS_HI     = 5'd1;
	localparam logic [SLOT_W-1:0] WS_XS_LO     = 5'd2;
	localparam logic [SLOT_W-1:0] WS_XE_HI     = 5'd3;
	localparam logic [SLOT_W-1:0] WS_XE_LO     = 5'd4;
	localparam logic [SLOT_W-1:0] WS_ROW_CMD   = 5'd5;
	localparam logic [SLOT_W-1:0] WS_YS_HI     = 5'd6;
	localparam logic [SLOT_W-1:0] WS_YS_LO     = 5'd7;
	localparam logic [SLOT_W-1:0] WS_YE_HI     = 5'd8;
	localparam logic [SLOT_W-1:0] WS_YE_LO     = 5'd9;
	localparam logic [SLOT_W-1:0] WS_WRITE_CMD = 5'd10;

	// pixel program slots
	localparam logic [SLOT_W-1:0] PS_HI = 5'd0;
	localparam logic [SLOT_W-1:0] PS_LO = 5'd1;

	// power/init program slots
	localparam logic [SLOT_W-1:0] OS_RAIL_ON       = 5'd0;
	localparam logic [SLOT_W-1:0] OS_PIN_HI        = 5'd1;
	localparam logic [SLOT_W-1:0] OS_PIN_LO        = 5'd2;
	localparam logic [SLOT_W-1:0] OS_PIN_REL       = 5'd3;
	localparam logic [SLOT_W-1:0] OS_SWRESET       = 5'd4;
	localparam logic [SLOT_W-1:0] OS_SLPOUT        = 5'd5;
	localparam logic [SLOT_W-1:0] OS_PIXFMT        = 5'd6;
	localparam logic [SLOT_W-1:0] OS_PIXFMT_DAT    = 5'd7;
	localparam logic [SLOT_W-1:0] OS_ADDR_MODE     = 5'd8;
	localparam logic [SLOT_W-1:0] OS_ADDR_MODE_DAT = 5'd9;
	localparam logic [SLOT_W-1:0] OS_INVERT        = 5'd10;
	localparam logic [SLOT_W-1:0] OS_NORMAL        = 5'd11;
	localparam logic [SLOT_W-1:0] OS_DISPON        = 5'd12;
	localparam logic [SLOT_W-1:0] OS_WAKE_SLPOUT   = 5'd13;
	localparam logic [SLOT_W-1:0] OS_WAKE_DISPON   = 5'd14;
	localparam logic [SLOT_W-1:0] OS_SLP_DISPOFF   = 5'd15;
	localparam logic [SLOT_W-1:0] OS_SLP_SLPIN     = 5'd16;
	localparam logic [SLOT_W-1:0] OS_RAIL_OFF      = 5'd17;

	localparam logic [NSLOT-1:0] MASK_WINDOW   = 18'h007FF;
	localparam logic [NSLOT-1:0] MASK_PIXEL    = 18'h00003;
	localparam logic [NSLOT-1:0] MASK_RAIL_ON  = 18'h00001;
	localparam logic [NSLOT-1:0] MASK_PIN      = 18'h0000E;
	localparam logic [NSLOT-1:0] MASK_INIT     = 18'h01FF0;
	localparam logic [NSLOT-1:0] MASK_WAKE     = 18'h06000;
	localparam logic [NSLOT-1:0] MASK_SLEEP    = 18'h18000;
	localparam logic [NSLOT-1:0] MASK_RAIL_OFF = 18'h20000;

	typedef enum logic [1:0] {
		PROG_WINDOW,
		PROG_PIXEL,
		PROG_POWER
	} prog_t;

	typedef struct packed {
		logic [9:0] column_offset;
		logic [9:0] row_offset;
		logic [7:0] memory_access_mode;
		logic       invert_colors;
		logic       has_reset_pin;
		logic       has_rail_control;
	} cfg_t;

	// one queued job: program, remaining slots and operand words
	typedef struct packed {
		prog_t            prog;
		logic [NSLOT-1:0] mask;
		logic [15:0]      w0;
		logic [15:0]      w1;
		logic [15:0]      w2;
		logic [15:0]      w3;
	} job_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       is_data;
		logic [6:0] wait_ms;
	} action_t;

endpackage

@@ design/spi_display_command_sequencer.sv @@
// Display command sequencer top level: configuration registers, front end,
// job queue and action sequencer. Depends on sds_pkg, sds_front, sds_queue, sds_back.
//
// Each accepted request becomes a list of link actions (command or data bytes,
// reset-pin levels, rail switches), delivered one per output beat with its
// wait time and a flag on the request's final action. The action sequencer
// emits one action per cycle unless out_ready stalls it; a request holds 2
// actions for a pixel, 11 for a window, up to 12 for init and up to 15 for a
// power request that leaves off; power requests that change nothing produce no
// beat. A request's job passes the job queue and the current-job register, and
// its first action is presented from the output register. A two-entry job queue
// lets new requests be accepted while earlier ones are still sent. The user must
// write configuration through cfg_we/cfg_index/cfg_data only while idle; unenforced.
module spi_display_command_sequencer import sds_pkg::*; #(
	parameter int COORD_WIDTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [9:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             req_type,
	input  logic [COORD_WIDTH-1:0] x_start,
	input  logic [COORD_WIDTH-1:0] y_start,
	input  logic [COORD_WIDTH-1:0] x_end,
	input  logic [COORD_WIDTH-1:0] y_end,
	input  logic [15:0]            pixel_value,
	input  logic [1:0]             power_target,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             action_kind,
	output logic [7:0]             action_value,
	output logic                   is_data,
	output logic [6:0]             wait_ms,
	output logic                   last_action
);

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{column_offset: 10'd0, row_offset: 10'd0,
				memory_access_mode: 8'd0, invert_colors: 1'b0,
				has_reset_pin: 1'b1, has_rail_control: 1'b0};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMN_OFFSET: cfg_q.column_offset      <= cfg_data;
				CFG_ROW_OFFSET:    cfg_q.row_offset         <= cfg_data;
				CFG_MEM_ACCESS:    cfg_q.memory_access_mode <= cfg_data[7:0];
				CFG_INVERT:        cfg_q.invert_colors      <= cfg_data[0];
				CFG_RESET_PIN:     cfg_q.has_reset_pin      <= cfg_data[0];
				CFG_RAIL_CTRL:     cfg_q.has_rail_control   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sds_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.pixel_value  (pixel_value),
		.power_target (power_target),
		.q_full       (q_full),
		.push         (push),
		.job          (push_job)
	);

	sds_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	sds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_head       (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action_kind  (action_kind),
		.action_value (action_value),
		.is_data      (is_data),
		.wait_ms      (wait_ms),
		.last_action  (last_action)
	);

endmodule

@@ design/sds_front.sv @@
// Front end: accepts requests, tracks the panel power state and turns each
// request into a job descriptor for the queue. Depends on sds_pkg.
module sds_front import sds_pkg::*; #(
	parameter int COORD_WIDTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             req_type,
	input  logic [COORD_WIDTH-1:0] x_start,
	input  logic [COORD_WIDTH-1:0] y_start,
	input  logic [COORD_WIDTH-1:0] x_end,
	input  logic [COORD_WIDTH-1:0] y_end,
	input  logic [15:0]            pixel_value,
	input  logic [1:0]             power_target,
	input  logic                   q_full,
	output logic                   push,
	output job_t                   job
);

	localparam logic [9:0] OFF_MASK = 10'((17'd1 << COORD_WIDTH) - 17'd1);

	pwr_state_t  power_state_q;
	pwr_state_t  power_state_d;
	logic [1:0]  target;
	logic        no_change;
	logic        keep;
	logic        accept;
	logic [16:0] col_off;
	logic [16:0] row_off;
	logic [16:0] xs_sum;
	logic [16:0] xe_sum;
	logic [16:0] ys_sum;
	logic [16:0] ye_sum;
	logic [NSLOT-1:0] init_mask;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && keep;

	assign col_off = 17'(cfg.column_offset & OFF_MASK);
	assign row_off = 17'(cfg.row_offset & OFF_MASK);
	assign xs_sum  = 17'(x_start) + col_off;
	assign xe_sum  = 17'(x_end) + col_off;
	assign ys_sum  = 17'(y_start) + row_off;
	assign ye_sum  = 17'(y_end) + row_off;

	assign init_mask = MASK_INIT | (cfg.has_reset_pin ? MASK_PIN : '0);

	always_comb begin
		// off collapses to sleep when the rail cannot be switched
		target = power_target;
		if (!cfg.has_rail_control && power_target == PWR_OFF) begin
			target = PWR_SLEEP;
		end
	end

	assign no_change = power_target == PWR_UNKNOWN || target == power_state_q;

	always_comb begin
		power_state_d = power_state_q;
		unique case (req_type)
			REQ_POWER: begin
				if (!no_change) begin
					power_state_d = pwr_state_t'(target);
				end
			end
			REQ_INIT: power_state_d = PWR_ON;
			default: ;
		endcase
	end

	always_comb begin
		keep     = 1'b1;
		job.prog = PROG_POWER;
		job.mask = '0;
		job.w0   = xs_sum[15:0];
		job.w1   = xe_sum[15:0];
		job.w2   = ys_sum[15:0];
		job.w3   = ye_sum[15:0];
		unique case (req_type)
			REQ_WINDOW: begin
				job.prog = PROG_WINDOW;
				job.mask = MASK_WINDOW;
			end
			REQ_PIXEL: begin
				job.prog = PROG_PIXEL;
				job.mask = MASK_PIXEL;
				job.w0   = pixel_value;
			end
			REQ_POWER: begin
				if (no_change) begin
					keep = 1'b0;
				end else if (power_state_q == PWR_OFF) begin
					job.mask = init_mask
						| (cfg.has_rail_control ? MASK_RAIL_ON : '0)
						| (target == PWR_SLEEP ? MASK_SLEEP : '0);
				end else if (target == PWR_ON) begin
					job.mask = MASK_WAKE;
				end else if (target == PWR_SLEEP) begin
					job.mask = MASK_SLEEP;
				end else begin
					job.mask = MASK_RAIL_OFF;
				end
			end
			default: begin
				job.mask = init_mask;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_state_q <= PWR_ON;
		end else if (accept) begin
			power_state_q <= power_state_d;
		end
	end

endmodule

@@ design/sds_queue.sv @@
// Two-entry job queue between the front end and the action sequencer.
// Depends on sds_pkg for the job descriptor type.
module sds_queue import sds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ design/sds_back.sv @@
// Back end: walks the slots of the current job, one action per cycle while the
// output is not stalled, into a registered output stage. Depends on sds_pkg.
module sds_back import sds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_empty,
	input  job_t       q_head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] action_kind,
	output logic [7:0] action_value,
	output logic       is_data,
	output logic [6:0] wait_ms,
	output logic       last_action
);

	job_t             cur_q;
	logic             cur_valid_q;
	logic             out_valid_q;
	action_t          out_act_q;
	logic             out_last_q;
	logic [SLOT_W-1:0] slot;
	logic [NSLOT-1:0] low_bit;
	logic [NSLOT-1:0] rest;
	logic             last;
	logic             fire;
	action_t          act;

	// lowest pending slot goes next
	always_comb begin
		slot = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (cur_q.mask[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

	assign low_bit = cur_q.mask & (~cur_q.mask + NSLOT'(1));
	assign rest    = cur_q.mask & ~low_bit;
	assign last    = rest == '0;
	assign fire    = cur_valid_q && (!out_valid_q || out_ready);
	assign pop     = !q_empty && (!cur_valid_q || (fire && last));

	always_comb begin
		act = '{kind: KIND_BYTE, value: 8'h00, is_data: 1'b0, wait_ms: 7'd0};
		unique case (cur_q.prog)
			PROG_WINDOW: begin
				act.is_data = 1'b1;
				unique case (slot)
					WS_COL_CMD: begin
						act.value   = CMD_COL_ADDR;
						act.is_data = 1'b0;
					end
					WS_XS_HI: act.value = cur_q.w0[15:8];
					WS_XS_LO: act.value = cur_q.w0[7:0];
					WS_XE_HI: act.value = cur_q.w1[15:8];
					WS_XE_LO: act.value = cur_q.w1[7:0];
					WS_ROW_CMD: begin
						act.value   = CMD_ROW_ADDR;
						act.is_data = 1'b0;
					end
					WS_YS_HI: act.value = cur_q.w2[15:8];
					WS_YS_LO: act.value = cur_q.w2[7:0];
					WS_YE_HI: act.value = cur_q.w3[15:8];
					WS_YE_LO: act.value = cur_q.w3[7:0];
					default: begin
						act.value   = CMD_MEM_WRITE;
						act.is_data = 1'b0;
					end
				endcase
			end
			PROG_PIXEL: begin
				act.is_data = 1'b1;
				act.value   = (slot == PS_HI) ? cur_q.w0[15:8] : cur_q.w0[7:0];
			end
			default: begin
				unique case (slot)
					OS_RAIL_ON: begin
						act.kind  = KIND_RAIL;
						act.value = 8'd1;
					end
					OS_PIN_HI: begin
						act.kind    = KIND_PIN;
						act.value   = 8'd1;
						act.wait_ms = 7'd10;
					end
					OS_PIN_LO: begin
						act.kind    = KIND_PIN;
						act.wait_ms = 7'd10;
					end
					OS_PIN_REL: begin
						act.kind    = KIND_PIN;
						act.value   = 8'd1;
						act.wait_ms = 7'd120;
					end
					OS_SWRESET: begin
						act.value   = CMD_SOFT_RESET;
						act.wait_ms = 7'd120;
					end
					OS_SLPOUT, OS_WAKE_SLPOUT: begin
						act.value   = CMD_SLEEP_OUT;
						act.wait_ms = 7'd120;
					end
					OS_PIXFMT: act.value = CMD_PIXEL_FMT;
					OS_PIXFMT_DAT: begin
						act.value   = PIXEL_FMT_565;
						act.is_data = 1'b1;
					end
					OS_ADDR_MODE: act.value = CMD_ADDR_MODE;
					OS_ADDR_MODE_DAT: begin
						act.value   = cfg.memory_access_mode;
						act.is_data = 1'b1;
					end
					OS_INVERT: act.value = cfg.invert_colors ? CMD_INVERT_ON : CMD_INVERT_OFF;
					OS_NORMAL: begin
						act.value   = CMD_NORMAL_MODE;
						act.wait_ms = 7'd10;
					end
					OS_DISPON, OS_WAKE_DISPON: begin
						act.value   = CMD_DISPLAY_ON;
						act.wait_ms = 7'd10;
					end
					OS_SLP_DISPOFF: act.value = CMD_DISPLAY_OFF;
					OS_SLP_SLPIN: begin
						act.value   = CMD_SLEEP_IN;
						act.wait_ms = 7'd5;
					end
					default: act.kind = KIND_RAIL;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (fire && last) begin
				cur_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end else if (fire) begin
			cur_q.mask <= rest;
		end
		if (fire) begin
			out_act_q  <= act;
			out_last_q <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign action_kind  = out_act_q.kind;
	assign action_value = out_act_q.value;
	assign is_data      = out_act_q.is_data;
	assign wait_ms      = out_act_q.wait_ms;
	assign last_action  = out_last_q;

endmodule
